FILE: design/grc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_pkg
// Shared constants, codes and types of the grid ray caster.
// ----------------------------------------------------------------------------
package grc_pkg;

    localparam int MAP_W     = 16;
    localparam int MAP_H     = 16;
    localparam int SCREEN_H  = 48;
    localparam int MID_ROW   = SCREEN_H / 2;
    localparam int MAP_DEPTH = MAP_W * MAP_H;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int COL_W     = $clog2(MAP_W);
    localparam int ROW_W     = $clog2(MAP_H);
    localparam int CELL_W    = 10;                  // signed walk coordinate
    localparam int WALK_MAX  = MAP_W + MAP_H + 2;   // steps before giving up
    localparam int WALK_CW   = $clog2(WALK_MAX + 1);
    localparam int RCP_STEPS = 17;                  // two quotient bits a cycle
    localparam int RCP_CW    = $clog2(RCP_STEPS);
    localparam int CFG_AW    = 5;

    localparam logic [31:0] ONE_FX = 32'h0001_0000;
    localparam logic [31:0] MAX32  = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32  = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_POS_X,
        REG_POS_Y,
        REG_DIR_X,
        REG_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y,
        REG_CAMERA_STEP
    } reg_idx_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_WRITE,
        OP_M1,
        OP_M2,
        OP_M3,
        OP_M4,
        OP_RAY,
        OP_DIVX,
        OP_CAP_FX,
        OP_CAP_FY,
        OP_SD2,
        OP_SD3,
        OP_WALK,
        OP_PROBE,
        OP_LAT,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_P4,
        OP_OUT
    } dp_op_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_M2,
        S_M3,
        S_M4,
        S_RAY,
        S_DIVX,
        S_WX,
        S_CAPX,
        S_WY,
        S_CAPY,
        S_SD2,
        S_SD3,
        S_WALK,
        S_PROBE,
        S_LAT,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_WP,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [17:0] dir_x;
        logic signed [17:0] dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
        logic [16:0]        camera_step;
    } cfg_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic is_write;
        logic walk_out;
        logic hit;
        logic walk_done;
        logic rcp_busy;
    } sts_t;

endpackage
`default_nettype wire

FILE: design/grc_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_in_if
// Input item channel: map writes and column casts.
// ----------------------------------------------------------------------------
interface grc_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [6:0] column;
    logic [3:0] cell_row;
    logic [3:0] cell_col;
    logic [7:0] cell_value;

    modport source (output valid, action, column, cell_row, cell_col, cell_value,
                    input ready);
    modport sink   (input valid, action, column, cell_row, cell_col, cell_value,
                    output ready);
endinterface
`default_nettype wire

FILE: design/grc_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_out_if
// Result item channel of the ray caster.
// ----------------------------------------------------------------------------
interface grc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] perp_dist;
    logic               side;
    logic [3:0]         hit_row;
    logic [3:0]         hit_col;
    logic [7:0]         hit_value;
    logic               left_map;
    logic [7:0]         wall_height;
    logic [4:0]         row_top;
    logic signed [7:0]  row_bottom;
    logic [6:0]         tex_offset;
    logic [4:0]         tex_column;

    modport source (output valid, perp_dist, side, hit_row, hit_col, hit_value,
                    left_map, wall_height, row_top, row_bottom, tex_offset,
                    tex_column, input ready);
    modport sink   (input valid, perp_dist, side, hit_row, hit_col, hit_value,
                    left_map, wall_height, row_top, row_bottom, tex_offset,
                    tex_column, output ready);
endinterface
`default_nettype wire

FILE: design/grc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: design/grc_recip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_recip
// Iterative signed reciprocal 2^32 / b, two quotient bits a cycle, saturated.
// ----------------------------------------------------------------------------
module grc_recip
    import grc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] b,
    output      logic        busy,
    output      logic [31:0] result
);

    logic              busy_reg;
    logic [RCP_CW-1:0] cnt_reg;
    logic [32:0]       rem_reg;
    logic [33:0]       q_reg;
    logic [31:0]       mag_reg;
    logic              neg_reg;

    logic [32:0] rem_next;
    logic [33:0] q_next;
    logic [32:0] trial;
    logic [5:0]  bit_idx;
    logic [31:0] q_sat;

    // restoring division of the constant 2^32, high quotient bits first
    always_comb
    begin
        rem_next = rem_reg;
        q_next   = q_reg;
        trial    = '0;
        bit_idx  = '0;
        for (int k = 1; k >= 0; k--)
        begin
            bit_idx = {cnt_reg, 1'b0} + 6'(k);
            trial   = {rem_next[31:0], (bit_idx == 6'd32)};
            if (trial >= {1'b0, mag_reg})
            begin
                rem_next = trial - {1'b0, mag_reg};
                q_next   = {q_next[32:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_next[32:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= (b != 32'd0);
            cnt_reg  <= RCP_CW'(RCP_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            if (b == 32'd0)
            begin
                q_reg   <= {2'b00, MAX32};
                neg_reg <= 1'b0;
            end
            else
            begin
                q_reg   <= '0;
                neg_reg <= b[31];
                mag_reg <= b[31] ? (32'd0 - b) : b;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign q_sat  = (q_reg > {2'b00, MAX32}) ? MAX32 : q_reg[31:0];
    assign result = neg_reg ? (32'd0 - q_sat) : q_sat;
    assign busy   = busy_reg;

endmodule
`default_nettype wire

FILE: design/grc_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_dp
// Ray caster datapath: shared multiplier, reciprocal unit, DDA walk, map RAM.
// ----------------------------------------------------------------------------
module grc_dp
    import grc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cfg_t               cfg,
    input  wire cmd_t               cmd,
    output      sts_t               sts,
    input  wire logic               in_action,
    input  wire logic [6:0]         in_column,
    input  wire logic [3:0]         in_cell_row,
    input  wire logic [3:0]         in_cell_col,
    input  wire logic [7:0]         in_cell_value,
    output      logic signed [31:0] perp_dist,
    output      logic               side,
    output      logic [3:0]         hit_row,
    output      logic [3:0]         hit_col,
    output      logic [7:0]         hit_value,
    output      logic               left_map,
    output      logic [7:0]         wall_height,
    output      logic [4:0]         row_top,
    output      logic signed [7:0]  row_bottom,
    output      logic [6:0]         tex_offset,
    output      logic [4:0]         tex_column
);

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] r;
        r = a + b;
        if ((a[31] == b[31]) && (r[31] != a[31]))
        begin
            r = a[31] ? MIN32 : MAX32;
        end
        return r;
    endfunction

    // latched item
    logic        act_reg;
    logic [6:0]  col_reg;
    logic [3:0]  row_reg;
    logic [3:0]  ccol_reg;
    logic [7:0]  val_reg;
    logic [MAP_AW-1:0] clr_reg;

    logic signed [65:0] prod_reg;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [31:0] imul_w;
    logic [31:0] lo_w;

    logic [31:0] m1x_reg, m1y_reg, tx_reg, rdx_reg, rdy_reg;
    logic [31:0] fx_reg, fy_reg, ddx_reg, ddy_reg, sdx_reg, sdy_reg;
    logic [31:0] lat_reg, perp_reg, wall_reg;
    logic signed [CELL_W-1:0] cx_reg, cy_reg;
    logic              side_reg;
    logic              left_reg;
    logic [7:0]        hv_reg;
    logic [WALK_CW-1:0] n_reg;

    logic [31:0] px32, py32, dx32, dy32, halfx, halfy;
    logic [32:0] fracx, fracy;
    logic        lt;
    logic signed [CELL_W-1:0] stx, sty, nx, ny;
    logic        out_x, out_y;
    logic [15:0] cx16, cy16;
    logic [31:0] lat_w;

    logic        rcp_start;
    logic [31:0] rcp_b;
    logic        rcp_busy;
    logic [31:0] rcp_res;

    logic              ram_we;
    logic [MAP_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [MAP_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic [7:0] h;
    logic [7:0] q1;
    logic [7:0] lh;
    logic [6:0] half_lh;
    logic [7:0] de_u;
    logic [4:0] ds_w;
    logic [6:0] toff_w;
    logic [7:0] de_w;

    assign px32  = {{14{cfg.plane_x[17]}}, cfg.plane_x};
    assign py32  = {{14{cfg.plane_y[17]}}, cfg.plane_y};
    assign dx32  = {{14{cfg.dir_x[17]}}, cfg.dir_x};
    assign dy32  = {{14{cfg.dir_y[17]}}, cfg.dir_y};
    assign halfx = {px32[31], px32[31:1]};
    assign halfy = {py32[31], py32[31:1]};
    assign fracx = rdx_reg[31] ? {17'd0, cfg.pos_x[15:0]}
                               : (33'h1_0000 - {17'd0, cfg.pos_x[15:0]});
    assign fracy = rdy_reg[31] ? {17'd0, cfg.pos_y[15:0]}
                               : (33'h1_0000 - {17'd0, cfg.pos_y[15:0]});
    assign imul_w = prod_reg[47:16];
    assign lo_w   = prod_reg[31:0];

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_M1:
            begin
                mul_a = {px32[31], px32};
                mul_b = {16'd0, cfg.camera_step};
            end
            OP_M2:
            begin
                mul_a = {py32[31], py32};
                mul_b = {16'd0, cfg.camera_step};
            end
            OP_M3:
            begin
                mul_a = {26'd0, col_reg};
                mul_b = {m1x_reg[31], m1x_reg};
            end
            OP_M4:
            begin
                mul_a = {26'd0, col_reg};
                mul_b = {m1y_reg[31], m1y_reg};
            end
            OP_CAP_FY:
            begin
                mul_a = fracx;
                mul_b = {ddx_reg[31], ddx_reg};
            end
            OP_SD2:
            begin
                mul_a = fracy;
                mul_b = {ddy_reg[31], ddy_reg};
            end
            OP_P1:
            begin
                mul_a = {lat_reg[31], lat_reg};
                mul_b = side_reg ? {fy_reg[31], fy_reg} : {fx_reg[31], fx_reg};
            end
            OP_P3:
            begin
                mul_a = {perp_reg[31], perp_reg};
                mul_b = side_reg ? {rdx_reg[31], rdx_reg} : {rdy_reg[31], rdy_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // reciprocal unit
    always_comb
    begin
        rcp_start = 1'b0;
        rcp_b     = rdx_reg;
        case (cmd.op)
            OP_DIVX:
            begin
                rcp_start = 1'b1;
                rcp_b     = rdx_reg;
            end
            OP_CAP_FX:
            begin
                rcp_start = 1'b1;
                rcp_b     = rdy_reg;
            end
            OP_P3:
            begin
                rcp_start = 1'b1;
                rcp_b     = perp_reg;
            end
            default:
            begin
                rcp_start = 1'b0;
                rcp_b     = rdx_reg;
            end
        endcase
    end

    grc_recip u_recip (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rcp_start),
        .b      (rcp_b),
        .busy   (rcp_busy),
        .result (rcp_res)
    );

    // one DDA step
    assign lt    = $signed(sdx_reg) < $signed(sdy_reg);
    assign stx   = rdx_reg[31] ? '1 : CELL_W'(1);
    assign sty   = rdy_reg[31] ? '1 : CELL_W'(1);
    assign nx    = lt ? (cx_reg + stx) : cx_reg;
    assign ny    = lt ? cy_reg : (cy_reg + sty);
    assign out_x = nx[CELL_W-1] || (nx[CELL_W-2:0] >= (CELL_W-1)'(MAP_W));
    assign out_y = ny[CELL_W-1] || (ny[CELL_W-2:0] >= (CELL_W-1)'(MAP_H));
    assign ram_raddr = {ny[ROW_W-1:0], nx[COL_W-1:0]};

    // distance along the ray to the wall face
    assign cx16  = {{(16 - CELL_W){cx_reg[CELL_W-1]}}, cx_reg};
    assign cy16  = {{(16 - CELL_W){cy_reg[CELL_W-1]}}, cy_reg};
    assign lat_w = side_reg
        ? ({cy16, 16'd0} - cfg.pos_y + (rdy_reg[31] ? ONE_FX : 32'd0))
        : ({cx16, 16'd0} - cfg.pos_x + (rdx_reg[31] ? ONE_FX : 32'd0));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = clr_reg;
        ram_wdata = '0;
        case (cmd.op)
            OP_CLEAR:
            begin
                ram_we = 1'b1;
            end
            OP_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = {row_reg[ROW_W-1:0], ccol_reg[COL_W-1:0]};
                ram_wdata = val_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    grc_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // wall height and draw rows from the reciprocal of the distance
    always_comb
    begin
        if (rcp_res[31])
        begin
            h = '0;
        end
        else if (rcp_res[30:18] != '0)
        begin
            h = 8'hFF;
        end
        else
        begin
            h = rcp_res[17:10];
        end
        q1      = {1'b0, h[7:1]} + 8'd1;
        lh      = h - {1'b0, q1[7:1]};
        half_lh = lh[7:1];
        if (half_lh > 7'(MID_ROW))
        begin
            ds_w   = '0;
            toff_w = half_lh - 7'(MID_ROW);
        end
        else
        begin
            ds_w   = 5'(7'(MID_ROW) - half_lh);
            toff_w = '0;
        end
        de_u = {1'b0, 7'((lh - 8'd1) >> 1)} + 8'(MID_ROW);
        if (lh == 8'd0)
        begin
            de_w = 8'(MID_ROW - 1);
        end
        else if (de_u >= 8'(SCREEN_H))
        begin
            de_w = 8'(SCREEN_H - 1);
        end
        else
        begin
            de_w = de_u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.op == OP_CLEAR)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                act_reg  <= in_action;
                col_reg  <= in_column;
                row_reg  <= in_cell_row;
                ccol_reg <= in_cell_col;
                val_reg  <= in_cell_value;
            end
            OP_M2:
            begin
                m1x_reg <= imul_w;
            end
            OP_M3:
            begin
                m1y_reg <= imul_w;
            end
            OP_M4:
            begin
                tx_reg <= lo_w;
            end
            OP_RAY:
            begin
                rdx_reg <= dx32 - halfx + tx_reg;
                rdy_reg <= dy32 - halfy + lo_w;
            end
            OP_CAP_FX:
            begin
                fx_reg  <= rcp_res;
                ddx_reg <= rdx_reg[31] ? (32'd0 - rcp_res) : rcp_res;
            end
            OP_CAP_FY:
            begin
                fy_reg  <= rcp_res;
                ddy_reg <= rdy_reg[31] ? (32'd0 - rcp_res) : rcp_res;
            end
            OP_SD2:
            begin
                sdx_reg <= imul_w;
            end
            OP_SD3:
            begin
                sdy_reg  <= imul_w;
                cx_reg   <= {{(CELL_W - 8){cfg.pos_x[23]}}, cfg.pos_x[23:16]};
                cy_reg   <= {{(CELL_W - 8){cfg.pos_y[23]}}, cfg.pos_y[23:16]};
                side_reg <= 1'b0;
                left_reg <= 1'b1;
                hv_reg   <= '0;
                n_reg    <= '0;
            end
            OP_WALK:
            begin
                cx_reg   <= nx;
                cy_reg   <= ny;
                side_reg <= !lt;
                n_reg    <= n_reg + 1'b1;
                if (lt)
                begin
                    sdx_reg <= sat_add(sdx_reg, ddx_reg);
                end
                else
                begin
                    sdy_reg <= sat_add(sdy_reg, ddy_reg);
                end
            end
            OP_PROBE:
            begin
                hv_reg <= ram_rdata;
                if (ram_rdata != '0)
                begin
                    left_reg <= 1'b0;
                end
            end
            OP_LAT:
            begin
                lat_reg <= lat_w;
            end
            OP_P2:
            begin
                perp_reg <= imul_w;
            end
            OP_P4:
            begin
                wall_reg <= (side_reg ? cfg.pos_x : cfg.pos_y) + imul_w;
            end
            OP_OUT:
            begin
                if (!act_reg)
                begin
                    perp_dist   <= '0;
                    side        <= 1'b0;
                    hit_row     <= '0;
                    hit_col     <= '0;
                    hit_value   <= '0;
                    left_map    <= 1'b0;
                    wall_height <= '0;
                    row_top     <= '0;
                    row_bottom  <= '0;
                    tex_offset  <= '0;
                    tex_column  <= '0;
                end
                else
                begin
                    perp_dist   <= perp_reg;
                    side        <= side_reg;
                    hit_row     <= left_reg ? 4'd0 : cy_reg[3:0];
                    hit_col     <= left_reg ? 4'd0 : cx_reg[3:0];
                    hit_value   <= left_reg ? 8'd0 : hv_reg;
                    left_map    <= left_reg;
                    wall_height <= lh;
                    row_top     <= ds_w;
                    row_bottom  <= de_w;
                    tex_offset  <= toff_w;
                    tex_column  <= {wall_reg[15:12], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign sts.clear_last = (clr_reg == '1);
    assign sts.is_write   = !act_reg;
    assign sts.walk_out   = out_x || out_y;
    assign sts.hit        = (ram_rdata != '0);
    assign sts.walk_done  = (n_reg == WALK_CW'(WALK_MAX));
    assign sts.rcp_busy   = rcp_busy;

endmodule
`default_nettype wire

FILE: design/grc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grc_ctrl
// Ray caster sequencer: steps the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module grc_ctrl
    import grc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output      logic in_ready,
    input  wire logic out_ready,
    output      logic out_valid,
    input  wire sts_t sts,
    output      cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:  state_next = sts.clear_last ? S_IDLE : S_CLEAR;
            S_IDLE:   state_next = in_valid ? S_DECIDE : S_IDLE;
            S_DECIDE: state_next = sts.is_write ? S_FINISH : S_M2;
            S_M2:     state_next = S_M3;
            S_M3:     state_next = S_M4;
            S_M4:     state_next = S_RAY;
            S_RAY:    state_next = S_DIVX;
            S_DIVX:   state_next = S_WX;
            S_WX:     state_next = sts.rcp_busy ? S_WX : S_CAPX;
            S_CAPX:   state_next = S_WY;
            S_WY:     state_next = sts.rcp_busy ? S_WY : S_CAPY;
            S_CAPY:   state_next = S_SD2;
            S_SD2:    state_next = S_SD3;
            S_SD3:    state_next = S_WALK;
            S_WALK:   state_next = sts.walk_out ? S_LAT : S_PROBE;
            S_PROBE:  state_next = (sts.hit || sts.walk_done) ? S_LAT : S_WALK;
            S_LAT:    state_next = S_P1;
            S_P1:     state_next = S_P2;
            S_P2:     state_next = S_P3;
            S_P3:     state_next = S_P4;
            S_P4:     state_next = S_WP;
            S_WP:     state_next = sts.rcp_busy ? S_WP : S_FINISH;
            S_FINISH: state_next = out_free ? S_IDLE : S_FINISH;
            default:  state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            S_CLEAR:  cmd.op = OP_CLEAR;
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.op   = in_valid ? OP_LOAD : OP_NONE;
            end
            S_DECIDE: cmd.op = sts.is_write ? OP_WRITE : OP_M1;
            S_M2:     cmd.op = OP_M2;
            S_M3:     cmd.op = OP_M3;
            S_M4:     cmd.op = OP_M4;
            S_RAY:    cmd.op = OP_RAY;
            S_DIVX:   cmd.op = OP_DIVX;
            S_CAPX:   cmd.op = OP_CAP_FX;
            S_CAPY:   cmd.op = OP_CAP_FY;
            S_SD2:    cmd.op = OP_SD2;
            S_SD3:    cmd.op = OP_SD3;
            S_WALK:   cmd.op = OP_WALK;
            S_PROBE:  cmd.op = OP_PROBE;
            S_LAT:    cmd.op = OP_LAT;
            S_P1:     cmd.op = OP_P1;
            S_P2:     cmd.op = OP_P2;
            S_P3:     cmd.op = OP_P3;
            S_P4:     cmd.op = OP_P4;
            S_FINISH: cmd.op = out_free ? OP_OUT : OP_NONE;
            default:  cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

FILE: design/grid_ray_caster_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_ray_caster_top
// DDA ray caster over a 16x16 byte map, one ray per screen column, 16.16.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   in_ch     sink       valid/ready      action, column, cell_row/col/value
//   out_ch    source     valid/ready      distance, side, cell, draw rows, tex
//   apb       slave      psel/penable     seven camera registers at 4*i
//
// A map write item is written in the decide state and its all-zero result is loaded in the
// finish state; the next item is taken only after that. A cast item walks up to 34 map
// cells; its time is set by three reciprocal runs on the shared divider and by the
// walk step of each cell (step, then registered map read).
// After reset all 256 entries of the map RAM are zeroed in one pass; no item is accepted
// until it ends, while register writes are taken.
// The finished result sits in the output register; the core only stalls at its
// last step if that register is still held by a stalled sink.
//
module grid_ray_caster_top
    import grc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    grc_in_if.sink                 in_ch,
    grc_out_if.source              out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output      logic [31:0]       prdata,
    output      logic              pready
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic cfg_wr;

    // camera registers, to be written by the user only while the block is idle; the block does not enforce it
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_x       <= 32'sd262144;
            cfg_reg.pos_y       <= 32'sd462848;
            cfg_reg.dir_x       <= 18'sd0;
            cfg_reg.dir_y       <= -18'sd65536;
            cfg_reg.plane_x     <= 18'sd65536;
            cfg_reg.plane_y     <= 18'sd0;
            cfg_reg.camera_step <= 17'd780;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[4:2]))
                REG_POS_X:       cfg_reg.pos_x       <= pwdata;
                REG_POS_Y:       cfg_reg.pos_y       <= pwdata;
                REG_DIR_X:       cfg_reg.dir_x       <= pwdata[17:0];
                REG_DIR_Y:       cfg_reg.dir_y       <= pwdata[17:0];
                REG_PLANE_X:     cfg_reg.plane_x     <= pwdata[17:0];
                REG_PLANE_Y:     cfg_reg.plane_y     <= pwdata[17:0];
                REG_CAMERA_STEP: cfg_reg.camera_step <= pwdata[16:0];
                default:
                begin
                end
            endcase
        end
    end

    // read back, direction and plane sign-extended to the bus, camera step zero-extended
    always_comb
    begin
        case (reg_idx_t'(paddr[4:2]))
            REG_POS_X:       prdata = cfg_reg.pos_x;
            REG_POS_Y:       prdata = cfg_reg.pos_y;
            REG_DIR_X:       prdata = {{14{cfg_reg.dir_x[17]}}, cfg_reg.dir_x};
            REG_DIR_Y:       prdata = {{14{cfg_reg.dir_y[17]}}, cfg_reg.dir_y};
            REG_PLANE_X:     prdata = {{14{cfg_reg.plane_x[17]}}, cfg_reg.plane_x};
            REG_PLANE_Y:     prdata = {{14{cfg_reg.plane_y[17]}}, cfg_reg.plane_y};
            REG_CAMERA_STEP: prdata = {15'd0, cfg_reg.camera_step};
            default:         prdata = '0;
        endcase
    end

    // sequencer: owns in_ch.ready and the output valid flag
    grc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: holds the item, the map and the result register
    grc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd           (cmd),
        .sts           (sts),
        .in_action     (in_ch.action),
        .in_column     (in_ch.column),
        .in_cell_row   (in_ch.cell_row),
        .in_cell_col   (in_ch.cell_col),
        .in_cell_value (in_ch.cell_value),
        .perp_dist     (out_ch.perp_dist),
        .side          (out_ch.side),
        .hit_row       (out_ch.hit_row),
        .hit_col       (out_ch.hit_col),
        .hit_value     (out_ch.hit_value),
        .left_map      (out_ch.left_map),
        .wall_height   (out_ch.wall_height),
        .row_top       (out_ch.row_top),
        .row_bottom    (out_ch.row_bottom),
        .tex_offset    (out_ch.tex_offset),
        .tex_column    (out_ch.tex_column)
    );

    // never overwrite a result that the sink has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!out_ch.valid || out_ch.ready))
        else $error("result register overwritten while held");

    // a ray that left the map reports no cell
    a_left_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.left_map) |->
        (out_ch.hit_value == 8'd0 && out_ch.hit_row == 4'd0 && out_ch.hit_col == 4'd0))
        else $error("left_map result carries a cell");

    // texture column is always an even byte column
    a_tex_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.tex_column[0] == 1'b0))
        else $error("odd texture column");

    // rows are cut off the top only when the wall starts at row zero
    a_clip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.row_top != 5'd0) |-> (out_ch.tex_offset == 7'd0))
        else $error("texture offset without clipping");

    // no item is taken during the map clearing pass
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_CLEAR) |-> !in_ch.ready)
        else $error("item accepted during map clear");

endmodule
`default_nettype wire
